/* hdl/gdad_pkg.sv */
`timescale 1ns / 1ps
package gdad_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 16;
	localparam int YCNT_W  = 15;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 24;

	localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
	localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

	localparam logic [YEAR_W-1:0] QUAD_CENTURY = 14'd400;
	localparam logic [YEAR_W-1:0] CENTURY      = 14'd100;
	localparam logic [YEAR_W-1:0] LAST_OF_CENT = 14'd99;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED400,
		ST_RED100,
		ST_SUM,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic red400;
		logic red100;
		logic sum_step;
		logic add_count;
		logic walk_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic ge400;
		logic ge100;
		logic sum_done;
		logic walk_done;
		logic out_free;
	} status_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* hdl/gregorian_date_add_days.sv */
`timescale 1ns / 1ps
// channel   dir  fields (lowest bit up)
// s_axis    in   start_day, start_month, start_year, days_to_add
// m_axis    out  result_day, result_month, result_year
//
// one word at a time: accept it, reduce the year by 400 while it is at least 400, then by
// 100 while it is at least 100, sum the months before the start, walk the months
// and load the output word; months walked is the start month offset plus the
// days added over about 30.4
// the month walk subtracts one month length per cycle
// the next input word is taken while a finished result waits in the output register
// reset clears the controller and the output valid flag only
module gregorian_date_add_days
	import gdad_pkg::*;
#(
	parameter int ADD_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // start_day, start_month, start_year, days_to_add, pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // result_day, result_month, result_year, pad
);

	cmd_t    cmd;
	status_t status;

	gdad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gdad_dp #(
		.ADD_WIDTH (ADD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata)
	);

endmodule

/* hdl/gdad_ctrl.sv */
`timescale 1ns / 1ps
module gdad_ctrl
	import gdad_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RED400;
				end
			end
			ST_RED400: begin
				if (status.ge400) begin
					cmd.red400 = 1'b1;
				end else begin
					state_d = ST_RED100;
				end
			end
			ST_RED100: begin
				if (status.ge100) begin
					cmd.red100 = 1'b1;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (status.sum_done) begin
					cmd.add_count = 1'b1;
					state_d       = ST_WALK;
				end else begin
					cmd.sum_step = 1'b1;
				end
			end
			ST_WALK: begin
				if (status.walk_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/gdad_dp.sv */
`timescale 1ns / 1ps
module gdad_dp
	import gdad_pkg::*;
#(
	parameter int ADD_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IN_W-1:0]    in_word,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   out_word
);

	localparam int ADD_EFF = (ADD_WIDTH < COUNT_W) ? ADD_WIDTH : COUNT_W;
	localparam int REM_W   = ADD_EFF + 2;

	logic [DAY_W-1:0]   in_day;
	logic [MONTH_W-1:0] in_month;
	logic [YEAR_W-1:0]  in_year;
	logic [COUNT_W-1:0] in_count;
	logic [MONTH_W-1:0] in_month_clamped;

	logic [YEAR_W-1:0]  yred_q;
	logic [1:0]         cent_q;
	logic [YCNT_W-1:0]  year_q;
	logic [MONTH_W-1:0] smon_q;
	logic [MONTH_W-1:0] mon_q;
	logic [REM_W-1:0]   rem_q;
	logic [ADD_EFF-1:0] add_q;

	logic [DAY_W-1:0]   rday_q;
	logic [MONTH_W-1:0] rmon_q;
	logic [YEAR_W-1:0]  ryear_q;
	logic               rvalid_q;

	logic               leap;
	logic [DAY_W-1:0]   len;
	logic [REM_W-1:0]   len_ext;

	assign in_day   = in_word[4:0];
	assign in_month = in_word[8:5];
	assign in_year  = in_word[22:9];
	assign in_count = in_word[38:23];

	always_comb begin
		in_month_clamped = in_month;
		if (in_month < JANUARY) begin
			in_month_clamped = JANUARY;
		end else if (in_month > DECEMBER) begin
			in_month_clamped = DECEMBER;
		end
	end

	// yred_q holds year mod 100 and cent_q the century mod 4 once reduced
	assign leap    = (yred_q[1:0] == 2'd0) && ((yred_q != '0) || (cent_q == 2'd0));
	assign len     = month_len(mon_q, leap);
	assign len_ext = REM_W'(len);

	assign status.ge400     = (yred_q >= QUAD_CENTURY);
	assign status.ge100     = (yred_q >= CENTURY);
	assign status.sum_done  = (mon_q >= smon_q);
	assign status.walk_done = (rem_q <= len_ext);
	assign status.out_free  = !rvalid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			yred_q <= in_year;
			cent_q <= 2'd0;
			year_q <= YCNT_W'(in_year);
			smon_q <= in_month_clamped;
			mon_q  <= JANUARY;
			rem_q  <= REM_W'(in_day);
			add_q  <= in_count[ADD_EFF-1:0];
		end else if (cmd.red400) begin
			yred_q <= yred_q - QUAD_CENTURY;
		end else if (cmd.red100) begin
			yred_q <= yred_q - CENTURY;
			cent_q <= cent_q + 2'd1;
		end else if (cmd.sum_step) begin
			rem_q <= rem_q + len_ext;
			mon_q <= mon_q + 4'd1;
		end else if (cmd.add_count) begin
			rem_q <= rem_q + REM_W'(add_q);
			mon_q <= JANUARY;
		end else if (cmd.walk_step) begin
			rem_q <= rem_q - len_ext;
			if (mon_q == DECEMBER) begin
				mon_q  <= JANUARY;
				year_q <= year_q + YCNT_W'(1);
				if (yred_q == LAST_OF_CENT) begin
					yred_q <= '0;
					cent_q <= cent_q + 2'd1;
				end else begin
					yred_q <= yred_q + YEAR_W'(1);
				end
			end else begin
				mon_q <= mon_q + 4'd1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rday_q  <= rem_q[DAY_W-1:0];
			rmon_q  <= mon_q;
			ryear_q <= year_q[YEAR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rvalid_q <= 1'b1;
		end else if (out_ready) begin
			rvalid_q <= 1'b0;
		end
	end

	assign out_valid = rvalid_q;
	assign out_word  = {1'b0, ryear_q, rmon_q, rday_q};

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
	import gdad_pkg::*;

	localparam int LIMIT       = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 2500;
	localparam int PHASE_WORDS = 83;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_out_t;

	class date_scoreboard;
		date_out_t expected_dates[$];
		int        failures = 0;

		function int unsigned month_days(int unsigned mo, int unsigned yr);
			bit leap;
			leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
			if (mo == FEBRUARY)
				return leap ? 29 : 28;
			if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
				return 30;
			return 31;
		endfunction

		function date_out_t advance_date(date_in_t d);
			date_out_t   r;
			longint      remain;
			int unsigned yr;
			int unsigned mo;
			int unsigned first_mo;
			yr = d.year;
			first_mo = (d.month < JANUARY) ? JANUARY : (d.month > DECEMBER) ? DECEMBER : d.month;
			remain = d.day;
			for (mo = JANUARY; mo < first_mo; mo++)
				remain += month_days(mo, yr);
			remain += d.count;
			mo = JANUARY;
			while (remain > month_days(mo, yr)) begin
				remain -= month_days(mo, yr);
				mo++;
				if (mo > DECEMBER) begin
					mo = JANUARY;
					yr++;
				end
			end
			r.day   = remain[DAY_W-1:0];
			r.month = mo[MONTH_W-1:0];
			r.year  = yr[YEAR_W-1:0];
			return r;
		endfunction

		function void note_start(date_in_t d);
			expected_dates.push_back(advance_date(d));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			date_out_t want;
			date_out_t got;
			got = word[DAY_W+MONTH_W+YEAR_W-1:0];
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %0d-%0d-%0d",
					$time, got.year, got.month, got.day);
				failures++;
				return;
			end
			want = expected_dates.pop_front();
			compare_field("result_day", want.day, got.day);
			compare_field("result_month", want.month, got.month);
			compare_field("result_year", want.year, got.year);
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	date_scoreboard sb;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	bit             hold_req = 1'b0;
	int             hold_left = 0;
	int             stalled_cycles = 0;

	gregorian_date_add_days #(
		.ADD_WIDTH(COUNT_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// result side: check, then pick ready for the next cycle
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic date_in_t make_date(int unsigned day, int unsigned month,
		int unsigned year, int unsigned count);
		date_in_t d;
		d.day   = DAY_W'(day);
		d.month = MONTH_W'(month);
		d.year  = YEAR_W'(year);
		d.count = COUNT_W'(count);
		return d;
	endfunction

	function automatic date_in_t rand_date();
		date_in_t d;
		d.day   = DAY_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
			$urandom_range(1, 28));
		d.month = MONTH_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) :
			$urandom_range(1, 12));
		d.year  = YEAR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) :
			$urandom_range(1583, 2400));
		case ($urandom_range(0, 15))
			0:       d.count = COUNT_W'($urandom_range(0, 65535));
			1, 2, 3: d.count = COUNT_W'($urandom_range(0, 31));
			default: d.count = COUNT_W'($urandom_range(0, 1500));
		endcase
		return d;
	endfunction

	task automatic send_word(date_in_t d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, d};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_start(d);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_idle_pct = 48;
		send_word(make_date(1, 1, 2000, 0));
		send_word(make_date(31, 12, 1999, 1));
		send_word(make_date(28, 2, 2000, 1));
		send_word(make_date(28, 2, 1900, 1));
		send_word(make_date(28, 2, 2004, 1));
		send_word(make_date(28, 2, 2001, 1));
		send_word(make_date(0, 1, 2020, 0));
		send_word(make_date(0, 3, 2020, 0));
		send_word(make_date(15, 0, 2021, 10));
		send_word(make_date(5, 13, 2021, 3));
		send_word(make_date(5, 15, 2021, 40));
		send_word(make_date(31, 2, 2021, 0));
		send_word(make_date(28, 2, 0, 1));
		send_word(make_date(1, 3, 0, 365));
		send_word(make_date(29, 2, 400, 365));
		send_word(make_date(1, 1, 1, 65535));
		send_word(make_date(31, 12, 9999, 65535));
		send_word(make_date(31, 12, 16383, 1));
		send_word(make_date(1, 1, 16383, 65535));
		send_word(make_date(31, 15, 16383, 65535));
		send_word(make_date(1, 1, 0, 0));
		send_word(make_date(30, 11, 2399, 31));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 6 : 0;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// long result stall while words keep coming
				if (phase == 0 && i == 10)
					hold_req = 1'b1;
				send_word(rand_date());
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* gregorian_date_add_days.f */
hdl/gdad_pkg.sv
hdl/gdad_ctrl.sv
hdl/gdad_dp.sv
hdl/gregorian_date_add_days.sv
tb/tb.sv
